// ===== rtl/core/icr_pkg.sv =====
// ----------------------------------------------------------------------------
// icr_pkg: shared types and constants for interior cell removal
// Grid limits, field widths, register indexes and beat structs.
// ----------------------------------------------------------------------------
package icr_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 256;

  localparam int CODE_W = 8;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);

  localparam int GRID_W_BITS = 10;
  localparam int GRID_H_BITS = 9;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam logic [CODE_W-1:0] CODE_EMPTY  = 8'd0;
  localparam logic [CODE_W-1:0] CODE_SOLID  = 8'd1;
  localparam logic [CODE_W-1:0] CODE_MARKED = 8'd2;

  localparam int RESET_WIDTH  = 300;
  localparam int RESET_HEIGHT = 250;

  typedef struct packed {
    logic [CODE_W-1:0] cell_code;
    logic              pad_item;
  } in_beat_t;

  typedef struct packed {
    logic [CODE_W-1:0] result_code;
    logic              frame_last;
  } out_beat_t;

  // neighborhood of one emitted cell plus its position flags
  typedef struct packed {
    logic [CODE_W-1:0] center;
    logic [CODE_W-1:0] up;
    logic [CODE_W-1:0] left;
    logic [CODE_W-1:0] right;
    logic [CODE_W-1:0] down;
    logic              has_up;
    logic              has_left;
    logic              has_right;
    logic              has_down;
  } win_t;

endpackage

// ===== rtl/core/interior_cell_removal.sv =====
// ----------------------------------------------------------------------------
// interior_cell_removal: 4-neighbor boundary extraction on a raster stream
//
// Cells arrive on the in_ channel in raster order, one beat per cell. The
// result for cell (r, c) leaves on the out_ channel when the cell below it,
// (r+1, c), is accepted; after the last row the feeder sends one flush row of
// beats, pad or not, each of which flushes the cell above it. The first row of a frame
// gives no result. Pad beats inside a frame are dropped. frame_last marks
// the final cell of the frame.
// A releasing beat passes through the window stage and the output register.
// Throughput: one beat per cycle while in_stall is low, through the registered
// read of the two row banks followed by one classify stage.
// Reset clears counters and loads width 300, height 250; the row banks are
// not cleared (every read hits data written earlier in the frame).
// cfg_ writes to the width or height index load a register (clamped to 1..max)
// and restart the frame; writes to other indexes are ignored. When out_stall
// holds, one result waits in the output register and one in the window stage;
// in_stall then rises until the output drains.
module interior_cell_removal (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  icr_pkg::in_beat_t                  in_beat,
  output logic                               out_valid,
  input  logic                               out_stall,
  output icr_pkg::out_beat_t                 out_beat,
  input  logic                               cfg_we,
  input  logic [icr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [icr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int COL_W  = icr_pkg::COL_W;
  localparam int ROW_W  = icr_pkg::ROW_W;
  localparam int CODE_W = icr_pkg::CODE_W;

  // configuration
  logic [COL_W-1:0] w_last_r, w_last_nxt;
  logic [ROW_W-1:0] h_eff_r, h_eff_nxt;
  logic             cfg_hit;

  // position counters
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // window stage
  logic              s1_valid_r;
  logic              s1_sel_r;
  logic [CODE_W-1:0] s1_code_r;
  logic              s1_has_up_r, s1_has_left_r, s1_has_right_r, s1_has_down_r;
  logic              s1_last_r;
  logic [CODE_W-1:0] left_r;

  // output register
  logic               out_valid_r;
  icr_pkg::out_beat_t out_beat_r;

  logic flush, accept, live, acc_emit, s1_adv;
  logic [1:0]        wr_en;
  logic [CODE_W-1:0] rd_a [2];
  logic [CODE_W-1:0] rd_b [2];
  logic [COL_W-1:0]  col_plus1;
  icr_pkg::win_t     win;
  logic [CODE_W-1:0] result_code;

  // ---------------- handshake ----------------
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign flush    = (row_r == h_eff_r);
  assign live     = accept && (flush || !in_beat.pad_item);
  assign acc_emit = live && (row_r != '0);

  assign col_plus1 = col_r + 1'b1;

  always_comb begin
    wr_en = 2'b00;
    if (live && !flush) begin
      wr_en[row_r[0]] = 1'b1;
    end
  end

  // ---------------- configuration ----------------
  always_comb begin
    cfg_hit    = 1'b0;
    w_last_nxt = w_last_r;
    h_eff_nxt  = h_eff_r;
    if (cfg_we) begin
      priority case (cfg_index)
        icr_pkg::REG_GRID_WIDTH: begin
          cfg_hit = 1'b1;
          if (cfg_data[icr_pkg::GRID_W_BITS-1:0] == '0) begin
            w_last_nxt = '0;
          end else if (32'(cfg_data[icr_pkg::GRID_W_BITS-1:0]) > icr_pkg::MAX_WIDTH) begin
            w_last_nxt = COL_W'(icr_pkg::MAX_WIDTH - 1);
          end else begin
            w_last_nxt = COL_W'(cfg_data[icr_pkg::GRID_W_BITS-1:0] - 1'b1);
          end
        end
        icr_pkg::REG_GRID_HEIGHT: begin
          cfg_hit = 1'b1;
          if (cfg_data[icr_pkg::GRID_H_BITS-1:0] == '0) begin
            h_eff_nxt = ROW_W'(1);
          end else if (32'(cfg_data[icr_pkg::GRID_H_BITS-1:0]) > icr_pkg::MAX_HEIGHT) begin
            h_eff_nxt = ROW_W'(icr_pkg::MAX_HEIGHT);
          end else begin
            h_eff_nxt = ROW_W'(cfg_data[icr_pkg::GRID_H_BITS-1:0]);
          end
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // ---------------- counters ----------------
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (live) begin
      if (col_r == w_last_r) begin
        col_nxt = '0;
        row_nxt = flush ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_plus1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= COL_W'(icr_pkg::RESET_WIDTH - 1);
      h_eff_r  <= ROW_W'(icr_pkg::RESET_HEIGHT);
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      w_last_r <= w_last_nxt;
      h_eff_r  <= h_eff_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  // ---------------- row banks ----------------
  for (genvar b = 0; b < 2; b++) begin : g_bank
    icr_ram #(
      .WIDTH (CODE_W),
      .DEPTH (icr_pkg::MAX_WIDTH)
    ) u_bank (
      .clk     (clk),
      .we      (wr_en[b]),
      .waddr   (col_r),
      .wdata   (in_beat.cell_code),
      .re      (acc_emit),
      .raddr_a (col_r),
      .raddr_b (col_plus1),
      .rdata_a (rd_a[b]),
      .rdata_b (rd_b[b])
    );
  end

  // ---------------- window stage ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc_emit) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_emit) begin
      s1_sel_r       <= row_r[0];
      s1_code_r      <= in_beat.cell_code;
      s1_has_up_r    <= (row_r != ROW_W'(1));
      s1_has_left_r  <= (col_r != '0);
      s1_has_right_r <= (col_r != w_last_r);
      s1_has_down_r  <= !flush;
      s1_last_r      <= flush && (col_r == w_last_r);
    end
    if (s1_adv) begin
      left_r <= win.center;
    end
  end

  // row r sits in the bank of opposite parity to the incoming row
  always_comb begin
    win.center    = s1_sel_r ? rd_a[0] : rd_a[1];
    win.right     = s1_sel_r ? rd_b[0] : rd_b[1];
    win.up        = s1_sel_r ? rd_a[1] : rd_a[0];
    win.left      = left_r;
    win.down      = s1_code_r;
    win.has_up    = s1_has_up_r;
    win.has_left  = s1_has_left_r;
    win.has_right = s1_has_right_r;
    win.has_down  = s1_has_down_r;
  end

  icr_classify u_classify (
    .win         (win),
    .result_code (result_code)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_beat_r.result_code <= result_code;
      out_beat_r.frame_last  <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // ---------------- assertions ----------------
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= w_last_r)
    else $error("column counter beyond grid width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= h_eff_r)
    else $error("row counter beyond flush row");

  a_emit_fills_window: assert property (@(posedge clk) disable iff (!rst_n)
    acc_emit |=> s1_valid_r)
    else $error("emitting beat lost before window stage");

  a_first_row_bank0: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en[1] |-> (row_r != '0) && !flush)
    else $error("odd bank written on first or flush row");

endmodule

// ===== rtl/core/icr_ram.sv =====
// ----------------------------------------------------------------------------
// icr_ram: generic RAM, one write port, two registered read ports
// Read-first: a read at the written address returns the old data.
// ----------------------------------------------------------------------------
module icr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/core/icr_classify.sv =====
// ----------------------------------------------------------------------------
// icr_classify: interior test for one cell
// Marked cells clear; solid cells with four solid or marked neighbors clear.
// ----------------------------------------------------------------------------
module icr_classify (
  input  icr_pkg::win_t                 win,
  output logic [icr_pkg::CODE_W-1:0]    result_code
);

  function automatic logic solidish(input logic [icr_pkg::CODE_W-1:0] v);
    return (v == icr_pkg::CODE_SOLID) || (v == icr_pkg::CODE_MARKED);
  endfunction

  logic interior;

  always_comb begin
    interior = (win.center == icr_pkg::CODE_SOLID) &&
               win.has_up && win.has_left && win.has_right && win.has_down &&
               solidish(win.up) && solidish(win.left) &&
               solidish(win.right) && solidish(win.down);
    if ((win.center == icr_pkg::CODE_MARKED) || interior) begin
      result_code = icr_pkg::CODE_EMPTY;
    end else begin
      result_code = win.center;
    end
  end

endmodule

// ===== bench/icr_checker.sv =====
// ----------------------------------------------------------------------------
// icr_checker: result predictor and scoreboard for interior cell removal
// Watches the cfg_, in_ and out_ ports, keeps its own copy of the grid
// registers, counters and row banks, predicts the cell released by each
// accepted in_ beat and compares every accepted out_ beat against the
// oldest prediction. Reports the mismatch count and outstanding results.
// ----------------------------------------------------------------------------
module icr_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  icr_pkg::in_beat_t              in_beat,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  icr_pkg::out_beat_t             out_beat,
  input  logic                           cfg_we,
  input  logic [icr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [icr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             results_seen
);

  localparam int REPORT_LIMIT = 10;
  localparam int MAX_WIDTH    = icr_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT   = icr_pkg::MAX_HEIGHT;
  localparam int CODE_W       = icr_pkg::CODE_W;
  localparam int GRID_W_BITS  = icr_pkg::GRID_W_BITS;
  localparam int GRID_H_BITS  = icr_pkg::GRID_H_BITS;

  logic [CODE_W-1:0]      row_banks [0:2*MAX_WIDTH-1];
  logic [GRID_W_BITS-1:0] width_reg;
  logic [GRID_H_BITS-1:0] height_reg;
  int unsigned            col_at;
  int unsigned            row_at;
  icr_pkg::out_beat_t     cells_due [$];
  icr_pkg::out_beat_t     oldest;
  int                     mismatches = 0;
  int                     compared   = 0;

  function automatic int unsigned bank_ix(int unsigned row, int unsigned col);
    return (row % 2) * MAX_WIDTH + col;
  endfunction

  function automatic bit is_filled(logic [CODE_W-1:0] v);
    return v == icr_pkg::CODE_SOLID || v == icr_pkg::CODE_MARKED;
  endfunction

  // advance the raster position by one beat; queue the released cell, if any
  task automatic absorb_cell(input icr_pkg::in_beat_t beat);
    int unsigned        w;
    int unsigned        h;
    int unsigned        c;
    int unsigned        rin;
    int unsigned        r;
    bit                 flush;
    bit                 interior;
    logic [CODE_W-1:0]  center;
    logic [CODE_W-1:0]  up;
    logic [CODE_W-1:0]  left;
    logic [CODE_W-1:0]  right;
    logic [CODE_W-1:0]  down;
    icr_pkg::out_beat_t due;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
    up    = icr_pkg::CODE_EMPTY;
    left  = icr_pkg::CODE_EMPTY;
    right = icr_pkg::CODE_EMPTY;
    down  = icr_pkg::CODE_EMPTY;
    if (col_at >= w) col_at = 0;
    if (row_at > h) row_at = 0;
    c     = col_at;
    rin   = row_at;
    flush = (rin == h);
    if (!flush && beat.pad_item) return;
    if (rin == 0) begin
      row_banks[bank_ix(0, c)] = beat.cell_code;
      col_at = c + 1;
      if (col_at >= w) begin
        col_at = 0;
        row_at = 1;
      end
      return;
    end
    r      = rin - 1;
    center = row_banks[bank_ix(r, c)];
    if (r > 0) up = row_banks[bank_ix(rin, c)];
    if (c > 0) left = row_banks[bank_ix(r, c - 1)];
    if (c + 1 < w) right = row_banks[bank_ix(r, c + 1)];
    if (!flush) begin
      down = beat.cell_code;
      row_banks[bank_ix(rin, c)] = beat.cell_code;
    end
    interior = center == icr_pkg::CODE_SOLID && r > 0 && c > 0 && c + 1 < w && !flush &&
               is_filled(up) && is_filled(left) && is_filled(right) && is_filled(down);
    due.result_code = (center == icr_pkg::CODE_MARKED || interior) ?
                      icr_pkg::CODE_EMPTY : center;
    due.frame_last  = (r == h - 1) && (c == w - 1);
    cells_due.push_back(due);
    col_at = c + 1;
    if (col_at >= w) begin
      col_at = 0;
      row_at = flush ? 0 : rin + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = GRID_W_BITS'(icr_pkg::RESET_WIDTH);
      height_reg = GRID_H_BITS'(icr_pkg::RESET_HEIGHT);
      col_at     = 0;
      row_at     = 0;
      for (int i = 0; i < 2 * MAX_WIDTH; i++) row_banks[i] = icr_pkg::CODE_EMPTY;
      cells_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          icr_pkg::REG_GRID_WIDTH: begin
            width_reg = cfg_data[GRID_W_BITS-1:0];
            col_at    = 0;
            row_at    = 0;
          end
          icr_pkg::REG_GRID_HEIGHT: begin
            height_reg = cfg_data[GRID_H_BITS-1:0];
            col_at     = 0;
            row_at     = 0;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) absorb_cell(in_beat);
      if (out_valid && !out_stall) begin
        compared++;
        if (cells_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result beat: code %0d last %0b",
                     out_beat.result_code, out_beat.frame_last);
        end else begin
          oldest = cells_due.pop_front();
          if (oldest.result_code !== out_beat.result_code ||
              oldest.frame_last !== out_beat.frame_last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("result %0d mismatch: expected code %0d last %0b, got code %0d last %0b",
                       compared, oldest.result_code, oldest.frame_last,
                       out_beat.result_code, out_beat.frame_last);
          end
        end
      end
    end
    fail_count   <= mismatches;
    pending      <= cells_due.size();
    results_seen <= compared;
  end

endmodule

// ===== bench/interior_cell_removal_tb.sv =====
// ----------------------------------------------------------------------------
// interior_cell_removal_tb: stimulus and verdict for interior cell removal
// Streams grids of cell codes with flush rows through the block under a
// range of grid sizes, including clamped and reset sizes, mid-frame
// restarts and writes to unused indexes. Both channels idle in random
// bursts; one long output hold fills the block. A separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module interior_cell_removal_tb;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 120;
  localparam int QUIET_ITEMS    = 60;
  localparam int SETTLE_CYCLES  = 8;

  localparam int CODE_W      = icr_pkg::CODE_W;
  localparam int CFG_IDX_W   = icr_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = icr_pkg::CFG_DATA_W;
  localparam int GRID_H_BITS = icr_pkg::GRID_H_BITS;
  localparam int MAX_WIDTH   = icr_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT  = icr_pkg::MAX_HEIGHT;

  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_HI = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  icr_pkg::in_beat_t     in_beat   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_stall;
  logic                  out_valid;
  icr_pkg::out_beat_t    out_beat;
  int                    fail_count;
  int                    pending;
  int                    results_seen;

  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int grid_w;
  int grid_h;
  int real_beats  = 0;
  int frames_done = 0;
  int idle_cycles = 0;
  int loop_start;
  int choice;
  bit noisy;

  logic [CODE_W-1:0] dir_cells [20] = '{
    8'd1, 8'd1, 8'd1,   8'd1, 8'd1,
    8'd1, 8'd1, 8'd1,   8'd2, 8'd1,
    8'd2, 8'd1, 8'd1,   8'd0, 8'd1,
    8'd1, 8'd1, 8'd255, 8'd1, 8'd7
  };
  logic [CODE_W-1:0] dir_flush [5] = '{8'd255, 8'd0, 8'd1, 8'd2, 8'd7};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  interior_cell_removal DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  icr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_beat      (in_beat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_beat     (out_beat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  function automatic logic [CODE_W-1:0] pick_code(bit wild);
    int roll;
    if (wild) return CODE_W'($urandom_range(0, 255));
    roll = $urandom_range(0, 19);
    if (roll < 9) return icr_pkg::CODE_SOLID;
    if (roll < 13) return icr_pkg::CODE_MARKED;
    if (roll < 17) return icr_pkg::CODE_EMPTY;
    return CODE_W'($urandom_range(0, 255));
  endfunction

  // valid stays high across back-to-back beats, apart from random idle gaps while not quiet
  task automatic send_beat(input logic [CODE_W-1:0] code, input logic pad);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{cell_code: code, pad_item: pad};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_bus;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    idle_bus();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] hd);
    cfg_write(icr_pkg::REG_GRID_WIDTH, wd);
    cfg_write(icr_pkg::REG_GRID_HEIGHT, hd);
    grid_w = (wd == 0) ? 1 : ((wd > MAX_WIDTH) ? MAX_WIDTH : int'(wd));
    grid_h = (hd[GRID_H_BITS-1:0] == 0) ? 1 :
             ((hd[GRID_H_BITS-1:0] > MAX_HEIGHT) ? MAX_HEIGHT : int'(hd[GRID_H_BITS-1:0]));
  endtask

  // in-frame cells, with stray pad beats mixed in
  task automatic send_cells(input int n, input bit wild);
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) send_beat(CODE_W'($urandom_range(0, 255)), 1'b1);
      send_beat(pick_code(wild), 1'b0);
      real_beats++;
    end
  endtask

  task automatic send_flush;
    repeat (grid_w) begin
      send_beat(CODE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      real_beats++;
    end
    frames_done++;
  endtask

  task automatic send_frame(input bit wild, input int hold_at, input int pause_at);
    int i;
    for (i = 0; i < grid_w * grid_h; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) idle_bus();
      send_cells(1, wild);
    end
    send_flush();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    grid_w = icr_pkg::RESET_WIDTH;
    grid_h = icr_pkg::RESET_HEIGHT;

    // reset sizes: first row plus the start of the second
    send_cells(icr_pkg::RESET_WIDTH + 5, 1'b0);

    // directed 5x4 grid: interiors, marked cells, odd codes, edges
    set_grid(10'd5, 10'd4);
    for (int i = 0; i < 20; i++) begin
      if (i == 2 || i == 7) send_beat(icr_pkg::CODE_SOLID, 1'b1);
      send_beat(dir_cells[i], 1'b0);
      real_beats++;
    end
    for (int i = 0; i < 5; i++) begin
      send_beat(dir_flush[i], (i % 2) == 0);
      real_beats++;
    end
    frames_done++;

    // unused indexes leave the frame running
    set_grid(10'd6, 10'd3);
    send_cells(8, 1'b0);
    cfg_write(REG_RESERVED_LO, CFG_DATA_W'($urandom_range(0, 1023)));
    cfg_write(REG_RESERVED_HI, CFG_DATA_W'($urandom_range(0, 1023)));
    send_cells(10, 1'b0);
    send_flush();

    // a register write mid-frame restarts it
    set_grid(10'd7, 10'd5);
    send_cells(17, 1'b0);
    set_grid(10'd4, 10'd3);
    send_frame(1'b0, -1, -1);

    // zero sizes clamp up, upper height bits are dropped
    set_grid(10'd0, 10'd0);
    send_frame(1'b0, -1, -1);
    set_grid(10'd2, 10'h202);
    send_frame(1'b1, -1, -1);
    set_grid(10'd3, 10'd3);
    send_frame(1'b0, -1, -1);

    // long output hold, then a full drain mid-frame
    set_grid(10'd10, 10'd8);
    send_frame(1'b0, 25, 55);

    loop_start = real_beats;
    while (real_beats - loop_start < RANDOM_ITEMS) begin
      if (real_beats - loop_start >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      choice = $urandom_range(0, 11);
      noisy  = ($urandom_range(0, 4) == 0);
      if (choice == 0) begin
        set_grid(CFG_DATA_W'($urandom_range(17, 64)), CFG_DATA_W'($urandom_range(0, 2)));
      end else begin
        set_grid(CFG_DATA_W'($urandom_range(0, 16)), CFG_DATA_W'($urandom_range(0, 10)));
      end
      if (choice == 1) send_cells($urandom_range(1, grid_w * grid_h), noisy);
      else send_frame(noisy, -1, -1);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    $display("Run covered %0d complete frames and %0d accepted cells, %0d results compared",
             frames_done, real_beats, results_seen);
    $display("Sizes ranged from 1x1 to the reset size, with restarts and a full backpressure hold");
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== interior_cell_removal.f =====
rtl/core/icr_pkg.sv
rtl/core/icr_ram.sv
rtl/core/icr_classify.sv
rtl/core/interior_cell_removal.sv
bench/icr_checker.sv
bench/interior_cell_removal_tb.sv
